// ----- rtl/core/bfa_pkg.sv -----
// Shared constants, codes and controller/datapath handshake types of the heap allocator.
package bfa_pkg;

  localparam int BFA_HEAP_BYTES      = 65536;
  localparam int BFA_CHUNK_BYTES     = 8192;
  localparam int BFA_HEADER_BYTES    = 16;
  localparam int BFA_MIN_SPLIT_BYTES = 17;
  localparam int BFA_FREE_SLOTS      = 32;
  localparam int BFA_USED_SLOTS      = 64;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TOO_LARGE = 3'd1,
    ST_NO_MEM    = 3'd2,
    ST_FREE_FULL = 3'd3,
    ST_USED_FULL = 3'd4,
    ST_UNKNOWN   = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    W_SLOT   = 3'd0,
    W_MATCH  = 3'd1,
    W_FIT    = 3'd2,
    W_POS    = 3'd3,
    W_REMOVE = 3'd4,
    W_INSERT = 3'd5
  } walk_t;

  typedef enum logic [2:0] {
    A_NONE     = 3'd0,
    A_GROW     = 3'd1,
    A_SPLIT    = 3'd2,
    A_USED_SET = 3'd3,
    A_MERGE    = 3'd4,
    A_PUT      = 3'd5,
    A_USED_CLR = 3'd6
  } act_t;

  typedef struct packed {
    logic    load;
    logic    go;
    walk_t   mode;
    logic    rm_pos;
    act_t    act;
    logic    res_load;
    status_t res_status;
    logic    res_take;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic is_free;
    logic zero_size;
    logic too_large;
    logic null_addr;
    logic slot_found;
    logic best_found;
    logic heap_full;
    logic grow_merge;
    logic free_full;
    logic split;
    logic left;
    logic right;
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/core/bfa_ifs.sv -----
// Request and response channel interfaces of the heap allocator.
interface bfa_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [15:0] req_size;
  logic [15:0] req_addr;

  modport source (output valid, output req_type, output req_size, output req_addr,
                  input ready);
  modport sink (input valid, input req_type, input req_size, input req_addr,
                output ready);
endinterface

interface bfa_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] user_addr;
  logic [2:0]  status;

  modport source (output valid, output user_addr, output status, input ready);
  modport sink (input valid, input user_addr, input status, output ready);
endinterface

// ----- rtl/core/best_fit_heap_allocator_core.sv -----
// Best-fit heap allocator with coalescing: top level.
// Channels: in_ch carries one request item (req_type 0 allocate with req_size,
// 1 free with req_addr); out_ch returns one item per request (user_addr, status).
// Both use valid/ready; an item moves when valid and ready are high at a clock edge.
// Requests are processed one at a time: in_ch.ready is high only while idle.
// Processing time is set by the table walker (one entry a cycle): an allocate searches
//   the used table for a free slot and walks the free table, again after a heap growth,
//   and walks it once more on a whole-segment take; a free searches the used table
//   for the match and walks the free table, again on an insert or a double merge.
//   Null, zero-size and too-large requests finish without a walk.
//   A failed used-slot search walks every used slot.
// The result sits in an output register; a new request is taken while it waits.
// A request that finishes while out_ch is still stalled holds until the
// register frees. Reset (rst_n low, synchronous) empties the free table,
// the heap and the used table; no clearing pass is needed.
module best_fit_heap_allocator_core #(
  parameter int HEAP_BYTES      = bfa_pkg::BFA_HEAP_BYTES,
  parameter int CHUNK_BYTES     = bfa_pkg::BFA_CHUNK_BYTES,
  parameter int HEADER_BYTES    = bfa_pkg::BFA_HEADER_BYTES,
  parameter int MIN_SPLIT_BYTES = bfa_pkg::BFA_MIN_SPLIT_BYTES,
  parameter int FREE_SLOTS      = bfa_pkg::BFA_FREE_SLOTS,
  parameter int USED_SLOTS      = bfa_pkg::BFA_USED_SLOTS
) (
  input logic      clk,
  input logic      rst_n,
  bfa_req_if.sink  in_ch,
  bfa_rsp_if.source out_ch
);
  import bfa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bfa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  bfa_dpath #(
    .HEAP_BYTES      (HEAP_BYTES),
    .CHUNK_BYTES     (CHUNK_BYTES),
    .HEADER_BYTES    (HEADER_BYTES),
    .MIN_SPLIT_BYTES (MIN_SPLIT_BYTES),
    .FREE_SLOTS      (FREE_SLOTS),
    .USED_SLOTS      (USED_SLOTS)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_req_type   (in_ch.req_type),
    .in_req_size   (in_ch.req_size),
    .in_req_addr   (in_ch.req_addr),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_user_addr (out_ch.user_addr),
    .out_status    (out_ch.status)
  );

endmodule

// ----- rtl/core/bfa_ctrl.sv -----
// Request sequencer of the heap allocator: one-hot state machine issuing datapath commands.
module bfa_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output bfa_pkg::cmd_t  cmd,
  input  bfa_pkg::sts_t  sts
);
  import bfa_pkg::*;

  typedef enum logic [17:0] {
    S_IDLE  = 18'h00001,
    S_CHECK = 18'h00002,
    S_SLOT  = 18'h00004,
    S_FIT1  = 18'h00008,
    S_GROW  = 18'h00010,
    S_REGO  = 18'h00020,
    S_FIT2  = 18'h00040,
    S_TAKE  = 18'h00080,
    S_RMA   = 18'h00100,
    S_USET  = 18'h00200,
    S_MATCH = 18'h00400,
    S_POS   = 18'h00800,
    S_RMF   = 18'h01000,
    S_RMF_W = 18'h02000,
    S_INS   = 18'h04000,
    S_PUT   = 18'h08000,
    S_FCLR  = 18'h10000,
    S_DONE  = 18'h20000
  } state_t;

  state_t  state_r, state_nxt;
  status_t res_status_r, res_status_nxt;
  logic    res_take_r, res_take_nxt;
  logic    fin;
  status_t fin_st;
  logic    fin_take;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    res_status_nxt = res_status_r;
    res_take_nxt   = res_take_r;
    fin            = 1'b0;
    fin_st         = ST_OK;
    fin_take       = 1'b0;
    cmd            = '0;
    cmd.mode       = W_SLOT;
    cmd.act        = A_NONE;
    cmd.res_status = res_status_r;
    cmd.res_take   = res_take_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.is_free) begin
          if (sts.null_addr) begin
            fin = 1'b1;
          end else begin
            cmd.go    = 1'b1;
            cmd.mode  = W_MATCH;
            state_nxt = S_MATCH;
          end
        end else if (sts.zero_size) begin
          fin = 1'b1;
        end else if (sts.too_large) begin
          fin    = 1'b1;
          fin_st = ST_TOO_LARGE;
        end else begin
          cmd.go    = 1'b1;
          cmd.mode  = W_SLOT;
          state_nxt = S_SLOT;
        end
      end
      S_SLOT: begin
        if (!sts.busy) begin
          if (!sts.slot_found) begin
            fin    = 1'b1;
            fin_st = ST_USED_FULL;
          end else begin
            cmd.go    = 1'b1;
            cmd.mode  = W_FIT;
            state_nxt = S_FIT1;
          end
        end
      end
      S_FIT1: begin
        if (!sts.busy) begin
          if (sts.best_found) begin
            state_nxt = S_TAKE;
          end else if (sts.heap_full) begin
            fin    = 1'b1;
            fin_st = ST_NO_MEM;
          end else if (!sts.grow_merge && sts.free_full) begin
            fin    = 1'b1;
            fin_st = ST_FREE_FULL;
          end else begin
            state_nxt = S_GROW;
          end
        end
      end
      S_GROW: begin
        cmd.act   = A_GROW;
        state_nxt = S_REGO;
      end
      S_REGO: begin
        cmd.go    = 1'b1;
        cmd.mode  = W_FIT;
        state_nxt = S_FIT2;
      end
      S_FIT2: begin
        if (!sts.busy) begin
          if (sts.best_found) begin
            state_nxt = S_TAKE;
          end else begin
            fin    = 1'b1;
            fin_st = ST_NO_MEM;
          end
        end
      end
      S_TAKE: begin
        if (sts.split) begin
          cmd.act   = A_SPLIT;
          state_nxt = S_USET;
        end else begin
          cmd.go    = 1'b1;
          cmd.mode  = W_REMOVE;
          state_nxt = S_RMA;
        end
      end
      S_RMA: begin
        if (!sts.busy) state_nxt = S_USET;
      end
      S_USET: begin
        cmd.act  = A_USED_SET;
        fin      = 1'b1;
        fin_take = 1'b1;
      end
      S_MATCH: begin
        if (!sts.busy) begin
          if (!sts.slot_found) begin
            fin    = 1'b1;
            fin_st = ST_UNKNOWN;
          end else begin
            cmd.go    = 1'b1;
            cmd.mode  = W_POS;
            state_nxt = S_POS;
          end
        end
      end
      S_POS: begin
        if (!sts.busy) begin
          if (sts.left || sts.right) begin
            cmd.act   = A_MERGE;
            state_nxt = (sts.left && sts.right) ? S_RMF : S_FCLR;
          end else if (sts.free_full) begin
            fin    = 1'b1;
            fin_st = ST_FREE_FULL;
          end else begin
            cmd.go    = 1'b1;
            cmd.mode  = W_INSERT;
            state_nxt = S_INS;
          end
        end
      end
      S_RMF: begin
        cmd.go     = 1'b1;
        cmd.mode   = W_REMOVE;
        cmd.rm_pos = 1'b1;
        state_nxt  = S_RMF_W;
      end
      S_RMF_W: begin
        if (!sts.busy) state_nxt = S_FCLR;
      end
      S_INS: begin
        if (!sts.busy) state_nxt = S_PUT;
      end
      S_PUT: begin
        cmd.act   = A_PUT;
        state_nxt = S_FCLR;
      end
      S_FCLR: begin
        cmd.act = A_USED_CLR;
        fin     = 1'b1;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (fin) begin
      state_nxt      = S_DONE;
      res_status_nxt = fin_st;
      res_take_nxt   = fin_take;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_status_r <= res_status_nxt;
    res_take_r   <= res_take_nxt;
  end

endmodule

// ----- rtl/core/bfa_dpath.sv -----
// Allocator datapath: free and used tables, table walker, arithmetic and result register.
module bfa_dpath #(
  parameter int HEAP_BYTES      = bfa_pkg::BFA_HEAP_BYTES,
  parameter int CHUNK_BYTES     = bfa_pkg::BFA_CHUNK_BYTES,
  parameter int HEADER_BYTES    = bfa_pkg::BFA_HEADER_BYTES,
  parameter int MIN_SPLIT_BYTES = bfa_pkg::BFA_MIN_SPLIT_BYTES,
  parameter int FREE_SLOTS      = bfa_pkg::BFA_FREE_SLOTS,
  parameter int USED_SLOTS      = bfa_pkg::BFA_USED_SLOTS
) (
  input  logic           clk,
  input  logic           rst_n,
  input  bfa_pkg::cmd_t  cmd,
  output bfa_pkg::sts_t  sts,
  input  logic           in_req_type,
  input  logic [15:0]    in_req_size,
  input  logic [15:0]    in_req_addr,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [15:0]    out_user_addr,
  output logic [2:0]     out_status
);
  import bfa_pkg::*;

  localparam int FIW = $clog2(FREE_SLOTS);
  localparam int UIW = $clog2(USED_SLOTS);
  localparam int FCW = $clog2(FREE_SLOTS + 1);
  localparam int UCW = $clog2(USED_SLOTS + 1);
  localparam int CW  = (FCW > UCW) ? FCW : UCW;
  localparam int AW  = 18;

  typedef struct packed {
    logic [15:0] start;
    logic [15:0] len;
  } ent_t;

  ent_t fmem [FREE_SLOTS];
  ent_t umem [USED_SLOTS];
  ent_t frd_r;
  ent_t urd_r;

  logic                  type_r;
  logic [15:0]           size_r;
  logic [15:0]           addr_r;
  logic [FCW-1:0]        free_cnt_r, cnt_nxt;
  logic [16:0]           heap_top_r, heap_nxt;
  logic [USED_SLOTS-1:0] used_vld_r, vld_nxt;

  logic          wk_busy_r, wk_busy_nxt;
  walk_t         wk_mode_r, wk_mode_nxt;
  logic [CW-1:0] wk_ic_r, wk_ic_nxt;
  logic [CW-1:0] wk_rem_r, wk_rem_nxt;
  logic          wk_up_r, wk_up_nxt;
  logic          wk_pend_r, wk_pend_nxt;
  logic [CW-1:0] wk_pidx_r, wk_pidx_nxt;

  logic           slot_found_r, slot_found_nxt;
  logic [UIW-1:0] slot_r, slot_nxt;
  logic [15:0]    ulen_r, ulen_nxt;
  logic           best_found_r, best_found_nxt;
  logic [FIW-1:0] best_idx_r, best_idx_nxt;
  logic [15:0]    best_start_r, best_start_nxt;
  logic [15:0]    best_len_r, best_len_nxt;
  logic [15:0]    last_start_r, last_start_nxt;
  logic [15:0]    last_len_r, last_len_nxt;
  logic [FCW-1:0] pos_r, pos_nxt;
  logic [15:0]    prev_start_r, prev_start_nxt;
  logic [15:0]    prev_len_r, prev_len_nxt;
  logic           has_next_r, has_next_nxt;
  logic [15:0]    next_start_r, next_start_nxt;
  logic [15:0]    next_len_r, next_len_nxt;

  logic           out_valid_r;
  logic [15:0]    out_addr_r;
  logic [2:0]     out_status_r;

  logic           we_f, we_u, rd_f, rd_u;
  logic [FIW-1:0] wa_f;
  ent_t           wd_f;
  logic           issue, hit;
  logic [CW-1:0]  cnt_w, rm_p;
  logic [FCW-1:0] cnt_m1;

  logic [15:0]    s_w, rem_w, take_addr, take_len;
  logic [AW-1:0]  hdr_a;
  logic           split, left, right, grow_merge;

  assign s_w       = addr_r - 16'(HEADER_BYTES);
  assign hdr_a     = AW'(HEADER_BYTES);
  assign rem_w     = best_len_r - size_r;
  assign split     = (rem_w >= 16'(MIN_SPLIT_BYTES)) && (rem_w > 16'(HEADER_BYTES));
  assign take_addr = split ? (best_start_r + rem_w + 16'(HEADER_BYTES))
                           : (best_start_r + 16'(HEADER_BYTES));
  assign take_len  = split ? size_r : best_len_r;
  assign cnt_m1    = free_cnt_r - FCW'(1);
  assign grow_merge = (free_cnt_r != '0) &&
                      (AW'(last_start_r) + hdr_a + AW'(last_len_r) == AW'(heap_top_r));
  assign left  = (pos_r != '0) &&
                 (AW'(prev_start_r) + hdr_a + AW'(prev_len_r) == AW'(s_w));
  assign right = has_next_r &&
                 (AW'(s_w) + hdr_a + AW'(ulen_r) == AW'(next_start_r));

  always_comb begin
    sts.busy       = wk_busy_r;
    sts.is_free    = type_r;
    sts.zero_size  = (size_r == '0);
    sts.too_large  = (AW'(size_r) + hdr_a) > AW'(CHUNK_BYTES);
    sts.null_addr  = (addr_r == '0);
    sts.slot_found = slot_found_r;
    sts.best_found = best_found_r;
    sts.heap_full  = (AW'(heap_top_r) + AW'(CHUNK_BYTES)) > AW'(HEAP_BYTES);
    sts.grow_merge = grow_merge;
    sts.free_full  = (free_cnt_r == FCW'(FREE_SLOTS));
    sts.split      = split;
    sts.left       = left;
    sts.right      = right;
    sts.out_free   = !out_valid_r || out_ready;
  end

  always_comb begin
    cnt_w = CW'(free_cnt_r);
    rm_p  = cmd.rm_pos ? CW'(pos_r) : CW'(best_idx_r);
    issue = wk_busy_r && (wk_rem_r != '0);
    hit   = 1'b0;

    wk_mode_nxt = wk_mode_r;
    wk_ic_nxt   = wk_ic_r;
    wk_rem_nxt  = wk_rem_r;
    wk_up_nxt   = wk_up_r;
    wk_pend_nxt = issue;
    wk_pidx_nxt = wk_ic_r;
    if (issue) begin
      wk_ic_nxt  = wk_up_r ? (wk_ic_r + CW'(1)) : (wk_ic_r - CW'(1));
      wk_rem_nxt = wk_rem_r - CW'(1);
    end
    rd_f = issue && (wk_mode_r != W_SLOT) && (wk_mode_r != W_MATCH);
    rd_u = issue && (wk_mode_r == W_MATCH);

    slot_found_nxt = slot_found_r;
    slot_nxt       = slot_r;
    ulen_nxt       = ulen_r;
    best_found_nxt = best_found_r;
    best_idx_nxt   = best_idx_r;
    best_start_nxt = best_start_r;
    best_len_nxt   = best_len_r;
    last_start_nxt = last_start_r;
    last_len_nxt   = last_len_r;
    pos_nxt        = pos_r;
    prev_start_nxt = prev_start_r;
    prev_len_nxt   = prev_len_r;
    has_next_nxt   = has_next_r;
    next_start_nxt = next_start_r;
    next_len_nxt   = next_len_r;

    we_f     = 1'b0;
    wa_f     = '0;
    wd_f     = '0;
    we_u     = 1'b0;
    cnt_nxt  = free_cnt_r;
    heap_nxt = heap_top_r;
    vld_nxt  = used_vld_r;

    if (wk_pend_r) begin
      case (wk_mode_r)
        W_SLOT: begin
          if (!slot_found_r && !used_vld_r[wk_pidx_r[UIW-1:0]]) begin
            slot_found_nxt = 1'b1;
            slot_nxt       = wk_pidx_r[UIW-1:0];
            hit            = 1'b1;
          end
        end
        W_MATCH: begin
          if (!slot_found_r && used_vld_r[wk_pidx_r[UIW-1:0]] && urd_r.start == addr_r) begin
            slot_found_nxt = 1'b1;
            slot_nxt       = wk_pidx_r[UIW-1:0];
            ulen_nxt       = urd_r.len;
            hit            = 1'b1;
          end
        end
        W_FIT: begin
          if (frd_r.len >= size_r && (!best_found_r || frd_r.len < best_len_r)) begin
            best_found_nxt = 1'b1;
            best_idx_nxt   = wk_pidx_r[FIW-1:0];
            best_start_nxt = frd_r.start;
            best_len_nxt   = frd_r.len;
          end
          last_start_nxt = frd_r.start;
          last_len_nxt   = frd_r.len;
        end
        W_POS: begin
          if (frd_r.start < s_w) begin
            pos_nxt        = FCW'(wk_pidx_r + CW'(1));
            prev_start_nxt = frd_r.start;
            prev_len_nxt   = frd_r.len;
          end else if (!has_next_r) begin
            has_next_nxt   = 1'b1;
            next_start_nxt = frd_r.start;
            next_len_nxt   = frd_r.len;
          end
        end
        W_REMOVE: begin
          we_f = 1'b1;
          wa_f = FIW'(wk_pidx_r - CW'(1));
          wd_f = frd_r;
        end
        W_INSERT: begin
          we_f = 1'b1;
          wa_f = FIW'(wk_pidx_r + CW'(1));
          wd_f = frd_r;
        end
        default: ;
      endcase
    end
    if (hit) wk_rem_nxt = '0;

    unique case (cmd.act)
      A_NONE: ;
      A_GROW: begin
        we_f     = 1'b1;
        heap_nxt = heap_top_r + 17'(CHUNK_BYTES);
        if (grow_merge) begin
          wa_f = cnt_m1[FIW-1:0];
          wd_f = '{start: last_start_r, len: last_len_r + 16'(CHUNK_BYTES)};
        end else begin
          wa_f    = free_cnt_r[FIW-1:0];
          wd_f    = '{start: heap_top_r[15:0], len: 16'(CHUNK_BYTES - HEADER_BYTES)};
          cnt_nxt = free_cnt_r + FCW'(1);
        end
      end
      A_SPLIT: begin
        we_f = 1'b1;
        wa_f = best_idx_r;
        wd_f = '{start: best_start_r, len: rem_w - 16'(HEADER_BYTES)};
      end
      A_USED_SET: begin
        we_u            = 1'b1;
        vld_nxt[slot_r] = 1'b1;
      end
      A_MERGE: begin
        we_f = 1'b1;
        if (left) begin
          wa_f = FIW'(pos_r - FCW'(1));
          wd_f = '{start: prev_start_r,
                   len: prev_len_r + 16'(HEADER_BYTES) + ulen_r +
                        (right ? (16'(HEADER_BYTES) + next_len_r) : 16'd0)};
        end else begin
          wa_f = pos_r[FIW-1:0];
          wd_f = '{start: s_w, len: next_len_r + 16'(HEADER_BYTES) + ulen_r};
        end
      end
      A_PUT: begin
        we_f    = 1'b1;
        wa_f    = pos_r[FIW-1:0];
        wd_f    = '{start: s_w, len: ulen_r};
        cnt_nxt = free_cnt_r + FCW'(1);
      end
      A_USED_CLR: begin
        vld_nxt[slot_r] = 1'b0;
      end
      default: ;
    endcase

    if (cmd.go) begin
      wk_mode_nxt = cmd.mode;
      wk_up_nxt   = 1'b1;
      wk_ic_nxt   = '0;
      case (cmd.mode)
        W_SLOT, W_MATCH: begin
          wk_rem_nxt     = CW'(USED_SLOTS);
          slot_found_nxt = 1'b0;
        end
        W_FIT: begin
          wk_rem_nxt     = cnt_w;
          best_found_nxt = 1'b0;
        end
        W_POS: begin
          wk_rem_nxt   = cnt_w;
          pos_nxt      = '0;
          has_next_nxt = 1'b0;
        end
        W_REMOVE: begin
          wk_ic_nxt  = rm_p + CW'(1);
          wk_rem_nxt = (cnt_w > rm_p + CW'(1)) ? (cnt_w - rm_p - CW'(1)) : '0;
          cnt_nxt    = cnt_m1;
        end
        W_INSERT: begin
          wk_up_nxt  = 1'b0;
          wk_ic_nxt  = cnt_w - CW'(1);
          wk_rem_nxt = cnt_w - CW'(pos_r);
        end
        default: wk_rem_nxt = '0;
      endcase
    end
    wk_busy_nxt = cmd.go || (wk_busy_r && ((wk_rem_nxt != '0) || wk_pend_nxt));
  end

  always_ff @(posedge clk) begin
    if (we_f) fmem[wa_f] <= wd_f;
    if (rd_f) frd_r <= fmem[wk_ic_r[FIW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (we_u) umem[slot_r] <= '{start: take_addr, len: take_len};
    if (rd_u) urd_r <= umem[wk_ic_r[UIW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_cnt_r   <= '0;
      heap_top_r   <= '0;
      used_vld_r   <= '0;
      wk_busy_r    <= 1'b0;
      wk_pend_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      slot_found_r <= 1'b0;
      best_found_r <= 1'b0;
      has_next_r   <= 1'b0;
    end else begin
      free_cnt_r   <= cnt_nxt;
      heap_top_r   <= heap_nxt;
      used_vld_r   <= vld_nxt;
      wk_busy_r    <= wk_busy_nxt;
      wk_pend_r    <= wk_pend_nxt;
      slot_found_r <= slot_found_nxt;
      best_found_r <= best_found_nxt;
      has_next_r   <= has_next_nxt;
      if (cmd.res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      type_r <= in_req_type;
      size_r <= in_req_size;
      addr_r <= in_req_addr;
    end
    if (cmd.res_load) begin
      out_addr_r   <= cmd.res_take ? take_addr : 16'd0;
      out_status_r <= cmd.res_status;
    end
    wk_mode_r    <= wk_mode_nxt;
    wk_ic_r      <= wk_ic_nxt;
    wk_rem_r     <= wk_rem_nxt;
    wk_up_r      <= wk_up_nxt;
    wk_pidx_r    <= wk_pidx_nxt;
    slot_r       <= slot_nxt;
    ulen_r       <= ulen_nxt;
    best_idx_r   <= best_idx_nxt;
    best_start_r <= best_start_nxt;
    best_len_r   <= best_len_nxt;
    last_start_r <= last_start_nxt;
    last_len_r   <= last_len_nxt;
    pos_r        <= pos_nxt;
    prev_start_r <= prev_start_nxt;
    prev_len_r   <= prev_len_nxt;
    next_start_r <= next_start_nxt;
    next_len_r   <= next_len_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_user_addr = out_addr_r;
  assign out_status    = out_status_r;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_cnt_r <= FCW'(FREE_SLOTS))
    else $error("free table count overflow");
  a_heap_bound: assert property (@(posedge clk) disable iff (!rst_n)
    heap_top_r <= 17'(HEAP_BYTES))
    else $error("heap top past limit");
  a_act_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.act != A_NONE) |-> !wk_busy_r)
    else $error("table action during walk");
  a_go_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.go |-> !wk_busy_r)
    else $error("walk restarted while busy");
  a_res_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |-> (!out_valid_r || out_ready))
    else $error("result register overwritten");
`endif

endmodule

// ----- dv/best_fit_heap_allocator_core_test.sv -----
// Testbench for the best-fit heap allocator: directed and random alloc/free traffic checked against a predictor.
`timescale 1ns / 100ps

module best_fit_heap_allocator_core_test;
  import bfa_pkg::*;

  localparam int HDR   = BFA_HEADER_BYTES;
  localparam int CHUNK = BFA_CHUNK_BYTES;

  typedef struct packed {
    logic [15:0] user_addr;
    status_t     status;
  } rsp_t;

  class heap_scoreboard;
    int unsigned fstart[BFA_FREE_SLOTS];
    int unsigned flen[BFA_FREE_SLOTS];
    int unsigned fcount;
    int unsigned top;
    int unsigned uaddr[BFA_USED_SLOTS];
    int unsigned ulen[BFA_USED_SLOTS];
    bit          uvalid[BFA_USED_SLOTS];
    rsp_t        pending[$];
    int          errors;
    int          checked;

    function new();
      fcount = 0;
      top = 0;
      errors = 0;
      checked = 0;
      foreach (uvalid[i]) uvalid[i] = 0;
    endfunction

    function void tab_remove(int unsigned p);
      for (int unsigned i = p; i + 1 < fcount; i++) begin
        fstart[i] = fstart[i+1];
        flen[i] = flen[i+1];
      end
      fcount--;
    endfunction

    function void tab_insert(int unsigned p, int unsigned s, int unsigned l);
      for (int unsigned i = fcount; i > p; i--) begin
        fstart[i] = fstart[i-1];
        flen[i] = flen[i-1];
      end
      fstart[p] = s;
      flen[p] = l;
      fcount++;
    endfunction

    function int smallest_fit(int unsigned size);
      int b;
      b = -1;
      for (int i = 0; i < fcount; i++)
        if (flen[i] >= size && (b < 0 || flen[i] < flen[b])) b = i;
      return b;
    endfunction

    function status_t allocate(int unsigned size, output logic [15:0] addr);
      int slot, b;
      int unsigned rem, seg, l;
      addr = 0;
      slot = -1;
      if (size == 0) return ST_OK;
      if (size + HDR > CHUNK) return ST_TOO_LARGE;
      for (int i = 0; i < BFA_USED_SLOTS; i++)
        if (!uvalid[i]) begin
          slot = i;
          break;
        end
      if (slot < 0) return ST_USED_FULL;
      b = smallest_fit(size);
      if (b < 0) begin
        if (top + CHUNK > BFA_HEAP_BYTES) return ST_NO_MEM;
        if (fcount > 0 && fstart[fcount-1] + HDR + flen[fcount-1] == top) begin
          flen[fcount-1] += CHUNK;
        end else begin
          if (fcount >= BFA_FREE_SLOTS) return ST_FREE_FULL;
          tab_insert(fcount, top, CHUNK - HDR);
        end
        top += CHUNK;
        b = smallest_fit(size);
        if (b < 0) return ST_NO_MEM;
      end
      rem = flen[b] - size;
      if (rem >= BFA_MIN_SPLIT_BYTES && rem > HDR) begin
        flen[b] = rem - HDR;
        seg = fstart[b] + HDR + flen[b];
        l = size;
      end else begin
        seg = fstart[b];
        l = flen[b];
        tab_remove(b);
      end
      uaddr[slot] = (seg + HDR) & 16'hFFFF;
      ulen[slot] = l & 16'hFFFF;
      uvalid[slot] = 1;
      addr = 16'(uaddr[slot]);
      return ST_OK;
    endfunction

    function status_t release_seg(int unsigned addr);
      int slot;
      int unsigned s, l, p;
      bit lft, rgt;
      slot = -1;
      if (addr == 0) return ST_OK;
      for (int i = 0; i < BFA_USED_SLOTS; i++)
        if (uvalid[i] && uaddr[i] == addr) begin
          slot = i;
          break;
        end
      if (slot < 0) return ST_UNKNOWN;
      s = addr - HDR;
      l = ulen[slot];
      p = 0;
      while (p < fcount && fstart[p] < s) p++;
      lft = (p > 0) && (fstart[p-1] + HDR + flen[p-1] == s);
      rgt = (p < fcount) && (s + HDR + l == fstart[p]);
      if (lft && rgt) begin
        flen[p-1] += HDR + l + HDR + flen[p];
        tab_remove(p);
      end else if (lft) begin
        flen[p-1] += HDR + l;
      end else if (rgt) begin
        fstart[p] = s;
        flen[p] += HDR + l;
      end else begin
        if (fcount >= BFA_FREE_SLOTS) return ST_FREE_FULL;
        tab_insert(p, s, l);
      end
      uvalid[slot] = 0;
      return ST_OK;
    endfunction

    function void note_request(logic rtype, logic [15:0] size, logic [15:0] addr);
      rsp_t r;
      if (rtype == 1'b0) r.status = allocate(32'(size), r.user_addr);
      else begin
        r.user_addr = 0;
        r.status = release_seg(32'(addr));
      end
      pending.push_back(r);
    endfunction

    function void check_result(logic [15:0] addr, logic [2:0] st);
      rsp_t e;
      checked++;
      if (pending.size() == 0) begin
        $error("unexpected result item user_addr=%0h status=%0d", addr, st);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (addr !== e.user_addr) begin
        $error("user_addr: expected %0h actual %0h", e.user_addr, addr);
        errors++;
      end
      if (st !== e.status) begin
        $error("status: expected %0d actual %0d", e.status, st);
        errors++;
      end
    endfunction

    function logic [15:0] live_addr();
      int idx[$];
      foreach (uvalid[i]) if (uvalid[i]) idx.push_back(i);
      if (idx.size() == 0) return 16'd0;
      return 16'(uaddr[idx[$urandom_range(idx.size()-1)]]);
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  bfa_req_if in_ch();
  bfa_rsp_if out_ch();
  heap_scoreboard sb;
  int hold_cycles = 0;
  int sent = 0;

  always #5 clk = ~clk;

  best_fit_heap_allocator_core u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  initial begin
    in_ch.valid = 0;
    in_ch.req_type = 0;
    in_ch.req_size = 0;
    in_ch.req_addr = 0;
    out_ch.ready = 0;
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.note_request(in_ch.req_type, in_ch.req_size, in_ch.req_addr);
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.user_addr, out_ch.status);
  end

  // receiver: random gaps, long hold when requested
  initial begin
    int w;
    @(negedge clk);
    while (1) begin
      if (hold_cycles > 0) begin
        out_ch.ready = 0;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
      end
      w = ($urandom_range(3) == 0) ? 0 : $urandom_range(8);
      if (w > 0) begin
        out_ch.ready = 0;
        repeat (w) @(negedge clk);
      end
      out_ch.ready = 1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  task automatic send(logic rtype, logic [15:0] size, logic [15:0] addr, int gap);
    in_ch.valid = 0;
    repeat (gap) @(negedge clk);
    in_ch.valid = 1;
    in_ch.req_type = rtype;
    in_ch.req_size = size;
    in_ch.req_addr = addr;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
    @(negedge clk);
    in_ch.valid = 0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  function automatic logic [15:0] pick_size();
    case ($urandom_range(9))
      0: return 16'($urandom_range(65535));
      1: return 16'(CHUNK - HDR - $urandom_range(1));
      2: return 16'($urandom_range(40));
      3, 4: return 16'($urandom_range(2000));
      default: return 16'($urandom_range(400));
    endcase
  endfunction

  task automatic random_item(int gap);
    int k;
    k = $urandom_range(99);
    if (k < 50) send(0, pick_size(), 16'($urandom), gap);
    else if (k < 90) send(1, 16'($urandom), sb.live_addr(), gap);
    else if (k < 95) send(1, 16'($urandom), 16'($urandom), gap);
    else send(1, 16'($urandom), sb.live_addr() + 16'(HDR), gap);
  endtask

  initial begin
    sb = new();
    repeat (10) @(negedge clk);
    rst_n = 1;
    @(negedge clk);
    send(0, 0, 0, 0);
    send(1, 16'hFFFF, 0, 0);
    send(0, 16'hFFFF, 16'hFFFF, 0);
    send(0, 16'(CHUNK - HDR + 1), 0, 0);
    send(0, 16'(CHUNK - HDR), 0, 0);
    send(1, 0, 16'd1234, 0);
    send(0, 100, 0, 0);
    send(0, 100, 0, 0);
    send(0, 8000, 0, 0);
    send(1, 0, sb.live_addr(), 0);
    send(1, 0, 16'(sb.uaddr[1]), 0);
    send(1, 0, 16'(sb.uaddr[1]), 0);
    send(0, 50, 0, 0);
    send(0, 1, 0, 1);
    for (int i = 0; i < 9; i++) send(0, 16'(CHUNK - HDR), 0, 0);
    drain();
    for (int i = 0; i < 80; i++) send(0, 16'(16 + $urandom_range(8)), 0, 0);
    for (int i = 0; i < 70; i++) send(1, 0, 16'(sb.uaddr[(i * 2) % BFA_USED_SLOTS]), 0);
    hold_cycles = 3000;
    for (int i = 0; i < 40; i++) random_item(0);
    drain();
    for (int i = 0; i < 60; i++) send(1, 0, sb.live_addr(), 0);
    for (int i = 0; i < 980; i++) begin
      if (i == 500) drain();
      random_item(($urandom_range(4) == 0) ? 0 : $urandom_range(8));
    end
    drain();
    $display("covered %0d requests, %0d results checked, incl. table-full and heap-limit cases",
             sent, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end
endmodule

// ----- best_fit_heap_allocator_core.f -----
rtl/core/bfa_pkg.sv
rtl/core/bfa_ifs.sv
rtl/core/bfa_ctrl.sv
rtl/core/bfa_dpath.sv
rtl/core/best_fit_heap_allocator_core.sv
dv/best_fit_heap_allocator_core_test.sv
